// File: rtl/lsml_pkg.sv
package lsml_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int MAX_LINE    = 200;

   localparam int BYTE_W  = 8;
   localparam int LINE_W  = 20;
   localparam int COL_W   = 8;
   localparam int LEN_W   = 5;
   localparam int WORD_W  = 64;
   localparam int INDEX_W = 2;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [LINE_W-1:0] LINE_LIMIT   = 20'hFFFFF;
   localparam logic [COL_W-1:0]  LAST_COLUMN  = COL_W'(MAX_LINE - 1);

   localparam logic [INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic [WORD_W-1:0] low_bytes;
      logic [WORD_W-1:0] high_bytes;
      logic [LEN_W-1:0]  length;
   } pattern_cfg_type;

   // Length zero behaves as one; anything above the window depth is clamped.
   function automatic logic [LEN_W-1:0] active_length(input logic [LEN_W-1:0] raw);
      logic [LEN_W-1:0] len;
      len = raw;
      if (len == '0) begin
         len = LEN_W'(1);
      end else if (len > LEN_W'(MAX_PATTERN)) begin
         len = LEN_W'(MAX_PATTERN);
      end
      return len;
   endfunction

endpackage

// File: rtl/lsml_window.sv
module lsml_window (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     shift_en,
   input  lsml_pkg::byte_type       text_byte,
   input  lsml_pkg::pattern_cfg_type pattern_cfg,
   output logic                     window_match
);
   import lsml_pkg::*;

   byte_type recent_ff [MAX_PATTERN];
   byte_type recent_in [MAX_PATTERN];
   byte_type pattern_bytes [MAX_PATTERN];
   byte_type aligned [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] lane_ok;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] src;

   // The window after the shift is what gets compared, newest byte in lane 0.
   always_comb begin
      recent_in[0] = text_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         recent_in[k] = recent_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_PATTERN; k++) begin
            recent_ff[k] <= '0;
         end
      end else if (shift_en) begin
         recent_ff <= recent_in;
      end
   end

   // Lane k faces pattern byte len-1-k; lanes past the length always agree.
   always_comb begin
      len = active_length(pattern_cfg.length);
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pattern_bytes[k] = (k < 8) ? pattern_cfg.low_bytes[(k % 8)*BYTE_W +: BYTE_W]
                                    : pattern_cfg.high_bytes[(k % 8)*BYTE_W +: BYTE_W];
      end
      src = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         src = LEN_W'(len - LEN_W'(1) - LEN_W'(k));
         aligned[k] = pattern_bytes[src[$clog2(MAX_PATTERN)-1:0]];
         lane_ok[k] = (LEN_W'(k) >= len) || (recent_in[k] == aligned[k]);
      end
      window_match = &lane_ok;
   end

endmodule

// File: rtl/line_substring_match_locator_core.sv
// A beat accepted from the request side is held in the input register and moves
// on into the result register whenever that register can take a new value.
// Throughput: one text byte per cycle while the result channel is not stalled;
// the rate is set by the window compare and the line bookkeeping.
// Bytes that complete no match produce no result beat.
// Reset (synchronous, active high) clears the window, the column and the
// overlap mark, sets the line number to one and loads the default pattern.
module line_substring_match_locator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_text_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [19:0]                 rsp_line_number,
   output logic [7:0]                  rsp_start_column,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lsml_pkg::INDEX_W-1:0] csr_index,
   input  logic [63:0]                 csr_data
);
   import lsml_pkg::*;

   // Configuration registers. Writes are to arrive only while the block is idle;
   // the block itself does not enforce this, and the port is always ready.
   pattern_cfg_type cfg_ff;
   pattern_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  cfg_in.low_bytes  = csr_data;
            CSR_PATTERN_HIGH: cfg_in.high_bytes = csr_data;
            CSR_PATTERN_LEN:  cfg_in.length     = csr_data[LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_bytes  <= '0;
         cfg_ff.high_bytes <= '0;
         cfg_ff.length     <= LEN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // Input register. The held byte moves on whenever the result register
   // can take a new value, whether or not this byte completes a match.
   logic     s1_valid_ff, s1_valid_in;
   byte_type s1_byte_ff;
   logic     req_accept;
   logic     out_free;
   logic     s2_fire;
   logic     rsp_valid_ff, rsp_valid_in;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s2_fire    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_text_byte;
      end
   end

   // Sliding window of the most recent bytes and the pattern compare.
   logic window_match;

   lsml_window u_window (
      .clock        (clock),
      .reset        (reset),
      .shift_en     (s2_fire),
      .text_byte    (s1_byte_ff),
      .pattern_cfg  (cfg_ff),
      .window_match (window_match)
   );

   // Line bookkeeping. The column counts bytes taken in the current line; the
   // blocked column is the last column covered by a reported match, which is
   // how overlapping candidates are dropped. Since all candidates share one
   // length, the earliest end is also the leftmost start.
   logic [COL_W-1:0]  column_ff, column_in;
   logic [COL_W-1:0]  blocked_ff, blocked_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  column_next;
   logic [COL_W-1:0]  len_col;
   logic [COL_W-1:0]  start_col;
   logic              hit;
   logic              line_end;

   always_comb begin
      len_col     = COL_W'(active_length(cfg_ff.length));
      column_next = column_ff + COL_W'(1);
      start_col   = column_next - len_col + COL_W'(1);
      // A candidate needs the whole pattern inside the current line.
      hit         = s2_fire && window_match && (column_next >= len_col)
                    && (start_col > blocked_ff);
      line_end    = (s1_byte_ff == NEWLINE_BYTE) || (column_next >= LAST_COLUMN);

      column_in  = column_ff;
      blocked_in = blocked_ff;
      line_in    = line_ff;
      if (s2_fire) begin
         if (line_end) begin
            column_in  = '0;
            blocked_in = '0;
            if (line_ff != LINE_LIMIT) begin
               line_in = line_ff + LINE_W'(1);
            end
         end else begin
            column_in = column_next;
            if (hit) begin
               blocked_in = column_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         blocked_ff <= '0;
         line_ff    <= LINE_W'(1);
      end else begin
         column_ff  <= column_in;
         blocked_ff <= blocked_in;
         line_ff    <= line_in;
      end
   end

   // Result register. It reloads whenever it is free; a byte without a match
   // simply leaves it empty.
   logic [LINE_W-1:0] rsp_line_ff;
   logic [COL_W-1:0]  rsp_column_ff;

   assign rsp_valid_in = out_free ? hit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         rsp_line_ff   <= line_ff;
         rsp_column_ff <= start_col;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_number  = rsp_line_ff;
   assign rsp_start_column = rsp_column_ff;

endmodule

// File: rtl/lsml_checker.sv
module lsml_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [19:0]                 rsp_line_number,
   input logic [7:0]                  rsp_start_column
);
   import lsml_pkg::*;

   // Nothing is reported in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_line_number)
                                    && $stable(rsp_start_column)))
      else $error("stalled result beat changed");

   // Line and column are one-based and the column stays inside a line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0) && (rsp_start_column != '0)
                    && (rsp_start_column <= LAST_COLUMN))
      else $error("result position out of range");

   // The input side only waits while a result beat is pending.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

endmodule

bind line_substring_match_locator_core lsml_checker u_lsml_checker (.*);
